### rtl/fcrd_pkg.sv
// Shared types, codes and constants of the front-coded record decoder.
package fcrd_pkg;

  // Default capacity of the name buffer in bytes
  localparam int unsigned NAME_CAP_DEFAULT = 512;

  // Result queue geometry
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Field lengths of the record format
  localparam logic [8:0] WIDE_FIELD_BYTES   = 9'd8;
  localparam logic [8:0] PARENT_FIELD_BYTES = 9'd4;

  // Result kinds
  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_NAME   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Block status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_IN_RECORD   = 2'd1;
  localparam logic [1:0] ST_COUNT_MISM  = 2'd2;
  localparam logic [1:0] ST_BYTES_MISM  = 2'd3;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_HAS_SIZE    = 3'd0,
    CFG_HAS_MTIME   = 3'd1,
    CFG_FOLDER      = 3'd2,
    CFG_RECORD_CNT  = 3'd3,
    CFG_BLOCK_BYTES = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        has_size;
    logic        has_mtime;
    logic        folder_records;
    logic [31:0] record_count;
    logic [47:0] block_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] record_index;
    logic [8:0]  name_length;
    logic [63:0] entry_size;
    logic [63:0] entry_mtime;
    logic [31:0] parent_index;
    logic        is_root;
    logic [7:0]  name_char;
    logic [1:0]  status;
  } result_t;

  // Up to two results handed to the queue in one cycle, r0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

### rtl/fcrd_parser.sv
// Record parser: parse state, name buffer memory and the result stage.
module fcrd_parser import fcrd_pkg::*; #(
  parameter int unsigned NameCapacity = NAME_CAP_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic       func_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  input  logic [8:0] read_pos_i,
  output push_t      push_o
);

  localparam int unsigned AddrW = $clog2(NameCapacity);
  localparam int unsigned LenW  = $clog2(NameCapacity + 1);

  typedef enum logic [7:0] {
    PH_START  = 8'b0000_0001,
    PH_DB_HI  = 8'b0000_0010,
    PH_KEEP   = 8'b0000_0100,
    PH_SLEN   = 8'b0000_1000,
    PH_SUFFIX = 8'b0001_0000,
    PH_SIZE   = 8'b0010_0000,
    PH_MTIME  = 8'b0100_0000,
    PH_PARENT = 8'b1000_0000
  } phase_e;

  // Parse state
  phase_e      phase_q, phase_d;
  logic [LenW-1:0] name_len_q, name_len_d;
  logic [7:0]  fcnt_q, fcnt_d;
  logic [63:0] fshift_q, fshift_d;
  logic [63:0] cap_size_q, cap_size_d;
  logic [63:0] cap_mtime_q, cap_mtime_d;
  logic [31:0] rec_done_q, rec_done_d;
  logic [47:0] bytes_seen_q, bytes_seen_d;

  // Name buffer
  logic [7:0]       name_mem [NameCapacity];
  logic             mem_we;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       ram_q;

  // Result stage
  logic    s1_rec_v_q, s1_st_v_q, s1_rd_v_q, s1_hit_q;
  result_t s1_rec_q, s1_st_q;
  result_t rec_res, st_res, rd_res;

  logic        push_go, read_go, read_hit;
  logic        rec_v, st_v;
  logic [LenW-1:0] len_base;
  logic [63:0] acc;
  logic [8:0]  fcnt_inc;
  logic [31:0] parent;
  logic [31:0] st_index;
  logic [1:0]  st_code;
  phase_e      after_name, after_size;

  assign push_go = accept_i & ~func_i;
  assign read_go = accept_i & func_i;

  assign after_size = cfg_i.has_mtime ? PH_MTIME : PH_PARENT;
  assign after_name = cfg_i.has_size ? PH_SIZE : after_size;

  // Little-endian field accumulation
  assign acc      = fshift_q | (64'(data_byte_i) << {fcnt_q[2:0], 3'b000});
  assign fcnt_inc = {1'b0, fcnt_q} + 9'd1;
  assign len_base = (bytes_seen_q == 48'd0) ? '0 : name_len_q;

  // Next parse state for a pushed byte
  always_comb begin
    phase_d      = phase_q;
    name_len_d   = name_len_q;
    fcnt_d       = fcnt_q;
    fshift_d     = fshift_q;
    cap_size_d   = cap_size_q;
    cap_mtime_d  = cap_mtime_q;
    rec_done_d   = rec_done_q;
    bytes_seen_d = bytes_seen_q;
    mem_we       = 1'b0;
    wr_addr      = '0;
    rec_v        = 1'b0;
    st_v         = 1'b0;
    parent       = acc[31:0];
    st_index     = '0;
    st_code      = ST_OK;
    if (push_go) begin
      name_len_d   = len_base;
      bytes_seen_d = bytes_seen_q + 48'd1;
      unique case (phase_q)
        PH_DB_HI: begin
          phase_d = PH_KEEP;
        end
        PH_KEEP: begin
          if (LenW'(data_byte_i) < len_base) name_len_d = LenW'(data_byte_i);
          phase_d = PH_SLEN;
        end
        PH_SLEN: begin
          fcnt_d = data_byte_i;
          if (data_byte_i == 8'd0) begin
            fcnt_d   = '0;
            fshift_d = '0;
            phase_d  = after_name;
          end else begin
            phase_d = PH_SUFFIX;
          end
        end
        PH_SUFFIX: begin
          // Append while there is room, drop the rest
          if (len_base < LenW'(NameCapacity)) begin
            mem_we     = 1'b1;
            wr_addr    = len_base[AddrW-1:0];
            name_len_d = len_base + LenW'(1);
          end
          fcnt_d = fcnt_q - 8'd1;
          if (fcnt_d == 8'd0) begin
            fshift_d = '0;
            phase_d  = after_name;
          end
        end
        PH_SIZE: begin
          fshift_d = acc;
          fcnt_d   = fcnt_inc[7:0];
          if (fcnt_inc >= WIDE_FIELD_BYTES) begin
            cap_size_d = acc;
            fcnt_d     = '0;
            fshift_d   = '0;
            phase_d    = after_size;
          end
        end
        PH_MTIME: begin
          fshift_d = acc;
          fcnt_d   = fcnt_inc[7:0];
          if (fcnt_inc >= WIDE_FIELD_BYTES) begin
            cap_mtime_d = acc;
            fcnt_d      = '0;
            fshift_d    = '0;
            phase_d     = PH_PARENT;
          end
        end
        PH_PARENT: begin
          fshift_d = acc;
          fcnt_d   = fcnt_inc[7:0];
          if (fcnt_inc >= PARENT_FIELD_BYTES) begin
            rec_v      = 1'b1;
            rec_done_d = rec_done_q + 32'd1;
            fcnt_d     = '0;
            fshift_d   = '0;
            phase_d    = PH_START;
          end
        end
        default: begin
          // Record start: clear per-record captures
          cap_size_d  = '0;
          cap_mtime_d = '0;
          fcnt_d      = '0;
          fshift_d    = '0;
          if (cfg_i.folder_records) begin
            phase_d = PH_DB_HI;
          end else begin
            if (LenW'(data_byte_i) < len_base) name_len_d = LenW'(data_byte_i);
            phase_d = PH_SLEN;
          end
        end
      endcase
      // Close the block
      if (last_i) begin
        st_v     = 1'b1;
        st_index = rec_done_d;
        if (phase_d != PH_START) begin
          st_code = ST_IN_RECORD;
        end else if (rec_done_d != cfg_i.record_count) begin
          st_code = ST_COUNT_MISM;
        end else if (bytes_seen_d != cfg_i.block_bytes) begin
          st_code = ST_BYTES_MISM;
        end else begin
          st_code = ST_OK;
        end
        phase_d      = PH_START;
        fcnt_d       = '0;
        fshift_d     = '0;
        cap_size_d   = '0;
        cap_mtime_d  = '0;
        rec_done_d   = '0;
        bytes_seen_d = '0;
      end
    end
  end

  // Assemble the results of this byte
  always_comb begin
    rec_res              = '0;
    rec_res.kind         = KIND_RECORD;
    rec_res.record_index = rec_done_q;
    rec_res.name_length  = name_len_d[8:0];
    rec_res.entry_size   = cap_size_q;
    rec_res.entry_mtime  = cap_mtime_q;
    rec_res.parent_index = parent;
    rec_res.is_root      = cfg_i.folder_records && (parent == rec_done_q);
    st_res               = '0;
    st_res.kind          = KIND_STATUS;
    st_res.record_index  = st_index;
    st_res.status        = st_code;
  end

  // Read lookup: hit only inside the current name
  assign read_hit = (32'(read_pos_i) < 32'(name_len_q)) &&
                    (32'(read_pos_i) < 32'(NameCapacity));
  assign rd_addr  = AddrW'(read_pos_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) name_mem[wr_addr] <= data_byte_i;
    if (read_go) ram_q <= name_mem[rd_addr];
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      name_len_q   <= '0;
      fcnt_q       <= '0;
      fshift_q     <= '0;
      cap_size_q   <= '0;
      cap_mtime_q  <= '0;
      rec_done_q   <= '0;
      bytes_seen_q <= '0;
    end else begin
      phase_q      <= phase_d;
      name_len_q   <= name_len_d;
      fcnt_q       <= fcnt_d;
      fshift_q     <= fshift_d;
      cap_size_q   <= cap_size_d;
      cap_mtime_q  <= cap_mtime_d;
      rec_done_q   <= rec_done_d;
      bytes_seen_q <= bytes_seen_d;
    end
  end

  // Result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_rec_v_q <= 1'b0;
      s1_st_v_q  <= 1'b0;
      s1_rd_v_q  <= 1'b0;
      s1_hit_q   <= 1'b0;
    end else begin
      s1_rec_v_q <= rec_v;
      s1_st_v_q  <= st_v;
      s1_rd_v_q  <= read_go;
      s1_hit_q   <= read_go & read_hit;
    end
  end

  // Result stage payload
  always_ff @(posedge clk_i) begin
    if (rec_v) s1_rec_q <= rec_res;
    if (st_v)  s1_st_q  <= st_res;
  end

  // Hand the stage to the queue, record before status
  always_comb begin
    rd_res           = '0;
    rd_res.kind      = KIND_NAME;
    rd_res.name_char = s1_hit_q ? ram_q : 8'd0;
    push_o.n  = 2'(s1_rd_v_q) + 2'(s1_rec_v_q) + 2'(s1_st_v_q);
    push_o.r0 = s1_rd_v_q ? rd_res : (s1_rec_v_q ? s1_rec_q : s1_st_q);
    push_o.r1 = s1_st_q;
  end

endmodule

### rtl/fcrd_result_fifo.sv
// Result queue that takes up to two results a cycle and delivers one on each pop.
module fcrd_result_fifo import fcrd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  push_t               push_i,
  input  logic                pop_i,
  output result_t             head_o,
  output logic [QUEUE_CW-1:0] count_o
);

  result_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0]  count_q, count_d;
  logic [QUEUE_AW-1:0]  wr_ptr_next;

  assign wr_ptr_next = wr_ptr_q + QUEUE_AW'(1);
  assign wr_ptr_d    = wr_ptr_q + QUEUE_AW'(push_i.n);
  assign rd_ptr_d    = rd_ptr_q + QUEUE_AW'(pop_i);
  assign count_d     = count_q + QUEUE_CW'(push_i.n) - QUEUE_CW'(pop_i);

  // Store incoming results
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) entries[wr_ptr_q] <= push_i.r0;
    if (push_i.n == 2'd2) entries[wr_ptr_next] <= push_i.r1;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head_o  = entries[rd_ptr_q];
  assign count_o = count_q;

endmodule

### rtl/front_coded_record_decoder_top.sv
// Top level of the front-coded record decoder: config registers and channels.
//
// Takes one byte of a front-coded record block, or one name read request, per
// cycle unless stalled. Each pushed byte updates the parse state and, in suffix
// phase, writes the name buffer (a one-port-write, one-port-read RAM of
// NameCapacity bytes); a read request reads that RAM. Results pass through the
// parse/RAM read stage, then an 8-deep result queue. A byte that both completes
// a record and ends the block yields two results; the input stalls only when
// the queue cannot absorb two more results, so the sustained rate is one item
// per cycle while the output drains one result per cycle. Configuration is
// written through cfg_we_i only while idle, a rule the block leaves to the user.
module front_coded_record_decoder_top import fcrd_pkg::*; #(
  parameter int unsigned NameCapacity = NAME_CAP_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic [8:0]  read_pos_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] record_index_o,
  output logic [8:0]  name_length_o,
  output logic [63:0] entry_size_o,
  output logic [63:0] entry_mtime_o,
  output logic [31:0] parent_index_o,
  output logic        is_root_o,
  output logic [7:0]  name_char_o,
  output logic [1:0]  status_o
);

  localparam int unsigned SumW = QUEUE_CW + 1;

  cfg_t                cfg_q;
  push_t               push;
  result_t             head;
  logic [QUEUE_CW-1:0] fifo_count;
  logic                in_accept, pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HAS_SIZE:    cfg_q.has_size       <= cfg_data_i[0];
        CFG_HAS_MTIME:   cfg_q.has_mtime      <= cfg_data_i[0];
        CFG_FOLDER:      cfg_q.folder_records <= cfg_data_i[0];
        CFG_RECORD_CNT:  cfg_q.record_count   <= cfg_data_i[31:0];
        CFG_BLOCK_BYTES: cfg_q.block_bytes    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold input while the queue lacks room for two more results
  assign in_stall_o = (SumW'(fifo_count) + SumW'(push.n)) > SumW'(QUEUE_DEPTH - 2);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign pop        = out_valid_o & ~out_stall_i;

  fcrd_parser #(
    .NameCapacity(NameCapacity)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (in_accept),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .read_pos_i  (read_pos_i),
    .push_o      (push)
  );

  fcrd_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (fifo_count)
  );

  // Drive the output channel from the queue head
  assign out_valid_o    = (fifo_count != '0);
  assign kind_o         = head.kind;
  assign record_index_o = head.record_index;
  assign name_length_o  = head.name_length;
  assign entry_size_o   = head.entry_size;
  assign entry_mtime_o  = head.entry_mtime;
  assign parent_index_o = head.parent_index;
  assign is_root_o      = head.is_root;
  assign name_char_o    = head.name_char;
  assign status_o       = head.status;

endmodule

### rtl/fcrd_checker.sv
// Port-level checks of the front-coded record decoder, bound to the top level.
module fcrd_checker import fcrd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [31:0] record_index_o,
  input logic [8:0]  name_length_o,
  input logic [63:0] entry_size_o,
  input logic [31:0] parent_index_o,
  input logic        is_root_o,
  input logic [7:0]  name_char_o,
  input logic [1:0]  status_o
);

  // Only the three result kinds appear
  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_RECORD || kind_o == KIND_NAME ||
                     kind_o == KIND_STATUS))
    else $error("unknown result kind");

  // Name reads carry nothing but the name byte
  a_name_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_NAME |->
      record_index_o == 32'd0 && name_length_o == 9'd0 &&
      parent_index_o == 32'd0 && status_o == ST_OK)
    else $error("name read result carries stray fields");

  // A record result has a clear status and name byte; a root record points at itself
  a_root_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_RECORD |->
      status_o == ST_OK && name_char_o == 8'd0 &&
      (!is_root_o || parent_index_o == record_index_o))
    else $error("record result inconsistent");

  // Status results leave record fields clear
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_STATUS |->
      name_char_o == 8'd0 && entry_size_o == 64'd0 && !is_root_o)
    else $error("status result carries stray fields");

  // A stalled result stays put
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(kind_o) && $stable(record_index_o) &&
      $stable(status_o))
    else $error("stalled result changed");

endmodule

bind front_coded_record_decoder_top fcrd_checker u_fcrd_checker (.*);
